FILE: design/assert_macros.svh
// Assertion macros shared by the RTL of the pointer selection block.
// No dependencies; simulation builds get the checks, synthesis gets empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// check a condition at every clock edge outside reset
`define AST_ALWAYS(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// check that an antecedent implies a consequent in the same cycle
`define AST_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// check that an antecedent implies a consequent in the following cycle
`define AST_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`else

`define AST_ALWAYS(lbl, cond, msg)
`define AST_SAME(lbl, ante, cons, msg)
`define AST_NEXT(lbl, ante, cons, msg)

`endif

`endif

FILE: design/prsel_pkg.sv
// Package for the pointer rectangle selection block: widths, codes, types.
// No dependencies.
`default_nettype none

package prsel_pkg;

   localparam int COORD_BITS = 12;
   localparam int THR_BITS   = 13;
   localparam int DIFF_W     = COORD_BITS + 1;
   localparam int CMP_W      = (DIFF_W > THR_BITS) ? DIFF_W : THR_BITS;

   localparam logic [THR_BITS-1:0] THR_RESET = THR_BITS'(3);

   localparam logic [1:0] MODE_PRESS   = 2'd0;
   localparam logic [1:0] MODE_MOVE    = 2'd1;
   localparam logic [1:0] MODE_RELEASE = 2'd2;
   localparam logic [1:0] MODE_UNDEF   = 2'd3;

   localparam logic [2:0] BTN_NONE   = 3'd0;
   localparam logic [2:0] BTN_LEFT   = 3'd1;
   localparam logic [2:0] BTN_RIGHT  = 3'd2;
   localparam logic [2:0] BTN_MIDDLE = 3'd3;
   localparam logic [2:0] BTN_OTHER  = 3'd4;

   localparam logic [1:0] FLOW_CLICK  = 2'd0;
   localparam logic [1:0] FLOW_SWEEP  = 2'd1;
   localparam logic [1:0] FLOW_MIDBTN = 2'd2;
   localparam logic [1:0] FLOW_MISC   = 2'd3;

   localparam logic KIND_UPDATE  = 1'b0;
   localparam logic KIND_RELEASE = 1'b1;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic [CMP_W-1:0] cmp_type;

   typedef struct packed {
      coord_type left;
      coord_type top;
      coord_type right;
      coord_type bottom;
   } rect_type;

   typedef struct packed {
      logic       result_kind;
      logic [1:0] flow;
      logic       has_preview;
      rect_type   preview;
      logic       committed;
      rect_type   commit;
   } rsp_item_type;

   // normalized rectangle spanned by two corner points
   function automatic rect_type make_rect(coord_type ax, coord_type ay,
                                          coord_type bx, coord_type by);
      rect_type r;
      r.left   = (ax < bx) ? ax : bx;
      r.top    = (ay < by) ? ay : by;
      r.right  = (ax > bx) ? ax : bx;
      r.bottom = (ay > by) ? ay : by;
      return r;
   endfunction

endpackage

`default_nettype wire

FILE: design/prsel_if.sv
// Channel interfaces of the pointer selection block: event input, result output,
// threshold write. Depends on prsel_pkg.
`default_nettype none

interface prsel_req_if;
   logic                  valid;
   logic                  ready;
   logic [1:0]            mode;
   logic [2:0]            button;
   prsel_pkg::coord_type  cursor_x;
   prsel_pkg::coord_type  cursor_y;

   modport source (output valid, mode, button, cursor_x, cursor_y, input ready);
   modport sink   (input valid, mode, button, cursor_x, cursor_y, output ready);
endinterface

interface prsel_rsp_if;
   logic                  valid;
   logic                  ready;
   logic                  result_kind;
   logic [1:0]            flow;
   logic                  has_preview;
   prsel_pkg::coord_type  preview_left;
   prsel_pkg::coord_type  preview_top;
   prsel_pkg::coord_type  preview_right;
   prsel_pkg::coord_type  preview_bottom;
   logic                  committed;
   prsel_pkg::coord_type  commit_left;
   prsel_pkg::coord_type  commit_top;
   prsel_pkg::coord_type  commit_right;
   prsel_pkg::coord_type  commit_bottom;

   modport source (output valid, result_kind, flow, has_preview, preview_left, preview_top,
                   preview_right, preview_bottom, committed, commit_left, commit_top,
                   commit_right, commit_bottom, input ready);
   modport sink   (input valid, result_kind, flow, has_preview, preview_left, preview_top,
                   preview_right, preview_bottom, committed, commit_left, commit_top,
                   commit_right, commit_bottom, output ready);
endinterface

interface prsel_csr_if;
   logic                                valid;
   logic                                ready;
   logic [prsel_pkg::THR_BITS-1:0]      data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

FILE: design/pointer_rectangle_selection_fsm.sv
// Pointer rectangle selection: turns press/move/release items into preview and
// committed rectangles. Depends on prsel_pkg, prsel_if and assert_macros.svh.
// An accepted item stays in the input register while the result register is full
// and not taken; then its result, if any, goes to the result register and rsp_ch.
// Throughput: one item per cycle while rsp_ch takes results; the input register
// and the result register each hold one item, and the state update is a single
// pass between them. Reset (synchronous, active high) clears all flags and the
// held button and anchor codes, empties both registers, and sets thr_ff to 3.
`default_nettype none
`include "assert_macros.svh"

module pointer_rectangle_selection_fsm (
   input  wire logic    clock,
   input  wire logic    reset,
   prsel_req_if.sink    req_ch,
   prsel_rsp_if.source  rsp_ch,
   prsel_csr_if.sink    csr_ch
);

   // ---------------------------------------------------------------------
   // Threshold register: writes are always taken.
   // ---------------------------------------------------------------------
   logic [prsel_pkg::THR_BITS-1:0] thr_ff;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= prsel_pkg::THR_RESET;
      end else if (csr_ch.valid) begin
         thr_ff <= csr_ch.data;
      end
   end

   // ---------------------------------------------------------------------
   // Input register and flow control
   // ---------------------------------------------------------------------
   logic                 s1_valid_ff;
   logic [1:0]           s1_mode_ff;
   logic [2:0]           s1_btn_ff;
   prsel_pkg::coord_type s1_cx_ff;
   prsel_pkg::coord_type s1_cy_ff;

   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   prsel_pkg::rsp_item_type rsp_item_ff;
   prsel_pkg::rsp_item_type rsp_item_in;

   logic out_free;
   logic s1_adv;
   logic req_fire;

   // the result register frees up when empty or when its item is taken now
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign s1_adv       = s1_valid_ff && out_free;
   assign req_ch.ready = !s1_valid_ff || out_free;
   assign req_fire     = req_ch.valid && req_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         s1_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_mode_ff <= req_ch.mode;
         s1_btn_ff  <= req_ch.button;
         s1_cx_ff   <= req_ch.cursor_x;
         s1_cy_ff   <= req_ch.cursor_y;
      end
   end

   // ---------------------------------------------------------------------
   // Selection state
   // ---------------------------------------------------------------------
   logic                 pressed_ff,      pressed_in;
   logic                 drag_ff,         drag_in;
   logic [2:0]           held_ff,         held_in;
   prsel_pkg::coord_type press_x_ff,      press_x_in;
   prsel_pkg::coord_type press_y_ff,      press_y_in;
   logic                 anchor_vld_ff,   anchor_vld_in;
   logic [2:0]           anchor_btn_ff,   anchor_btn_in;
   prsel_pkg::coord_type anchor_x_ff,     anchor_x_in;
   prsel_pkg::coord_type anchor_y_ff,     anchor_y_in;
   logic                 prev_vld_ff,     prev_vld_in;
   prsel_pkg::rect_type  prev_rect_ff,    prev_rect_in;

   // Manhattan distance from the press point
   logic signed [prsel_pkg::DIFF_W-1:0] dx, dy;
   logic [prsel_pkg::DIFF_W-1:0]        adx, ady, man_dist;
   logic                                dist_hit;

   assign dx   = {s1_cx_ff[prsel_pkg::COORD_BITS-1], s1_cx_ff}
               - {press_x_ff[prsel_pkg::COORD_BITS-1], press_x_ff};
   assign dy   = {s1_cy_ff[prsel_pkg::COORD_BITS-1], s1_cy_ff}
               - {press_y_ff[prsel_pkg::COORD_BITS-1], press_y_ff};
   assign adx  = dx[prsel_pkg::DIFF_W-1] ? -dx : dx;
   assign ady  = dy[prsel_pkg::DIFF_W-1] ? -dy : dy;
   assign man_dist = adx + ady;
   assign dist_hit = prsel_pkg::cmp_type'(man_dist) >= prsel_pkg::cmp_type'(thr_ff);

   // rectangles the different paths may report
   prsel_pkg::rect_type hover_rect, drag_rect, point_rect, last_rect;
   prsel_pkg::coord_type org_x, org_y;
   logic                 drag_now;

   assign org_x      = anchor_vld_ff ? anchor_x_ff : press_x_ff;
   assign org_y      = anchor_vld_ff ? anchor_y_ff : press_y_ff;
   assign hover_rect = prsel_pkg::make_rect(anchor_x_ff, anchor_y_ff, s1_cx_ff, s1_cy_ff);
   assign drag_rect  = prsel_pkg::make_rect(org_x, org_y, s1_cx_ff, s1_cy_ff);
   assign point_rect = prsel_pkg::make_rect(s1_cx_ff, s1_cy_ff, s1_cx_ff, s1_cy_ff);
   // an invalid preview reads as the null rectangle
   assign last_rect  = prev_vld_ff ? prev_rect_ff : '0;
   assign drag_now   = drag_ff || dist_hit;

   // ---------------------------------------------------------------------
   // Next state and result for the item in the input register
   // ---------------------------------------------------------------------
   logic                emit;
   prsel_pkg::rsp_item_type res;

   always_comb begin
      pressed_in    = pressed_ff;
      drag_in       = drag_ff;
      held_in       = held_ff;
      press_x_in    = press_x_ff;
      press_y_in    = press_y_ff;
      anchor_vld_in = anchor_vld_ff;
      anchor_btn_in = anchor_btn_ff;
      anchor_x_in   = anchor_x_ff;
      anchor_y_in   = anchor_y_ff;
      prev_vld_in   = prev_vld_ff;
      prev_rect_in  = prev_rect_ff;
      emit          = 1'b0;
      res           = '0;
      res.result_kind = prsel_pkg::KIND_RELEASE;
      res.flow        = prsel_pkg::FLOW_MISC;

      unique case (s1_mode_ff)
         prsel_pkg::MODE_PRESS: begin
            pressed_in = 1'b1;
            drag_in    = 1'b0;
            press_x_in = s1_cx_ff;
            press_y_in = s1_cy_ff;
            held_in    = s1_btn_ff;
         end
         prsel_pkg::MODE_MOVE: begin
            res.result_kind = prsel_pkg::KIND_UPDATE;
            if (!pressed_ff) begin
               // hover preview from the anchor
               if (anchor_vld_ff) begin
                  prev_rect_in    = hover_rect;
                  prev_vld_in     = 1'b1;
                  emit            = 1'b1;
                  res.flow        = prsel_pkg::FLOW_CLICK;
                  res.has_preview = 1'b1;
                  res.preview     = hover_rect;
               end
            end else begin
               drag_in = drag_now;
               if (drag_now && held_ff == prsel_pkg::BTN_LEFT) begin
                  prev_rect_in    = drag_rect;
                  prev_vld_in     = 1'b1;
                  emit            = 1'b1;
                  res.flow        = prsel_pkg::FLOW_SWEEP;
                  res.has_preview = 1'b1;
                  res.preview     = drag_rect;
               end
            end
         end
         prsel_pkg::MODE_RELEASE: begin
            emit = 1'b1;
            priority if (s1_btn_ff == prsel_pkg::BTN_MIDDLE) begin
               pressed_in = 1'b0;
               res.flow   = prsel_pkg::FLOW_MIDBTN;
            end else if (!pressed_ff) begin
               // unmatched release: report only, state stays
               res.flow = prsel_pkg::FLOW_MISC;
            end else if (s1_btn_ff != held_ff) begin
               pressed_in = 1'b0;
               res.flow   = prsel_pkg::FLOW_MISC;
            end else if (drag_ff && held_ff == prsel_pkg::BTN_LEFT) begin
               // drag done: commit the last preview
               pressed_in      = 1'b0;
               res.flow        = prsel_pkg::FLOW_SWEEP;
               res.has_preview = prev_vld_ff;
               res.preview     = last_rect;
               res.committed   = 1'b1;
               res.commit      = last_rect;
               drag_in         = 1'b0;
               anchor_vld_in   = 1'b0;
               anchor_btn_in   = prsel_pkg::BTN_NONE;
               prev_vld_in     = 1'b0;
               held_in         = prsel_pkg::BTN_NONE;
            end else if (held_ff == prsel_pkg::BTN_LEFT ||
                         held_ff == prsel_pkg::BTN_RIGHT) begin
               pressed_in = 1'b0;
               drag_in    = 1'b0;
               held_in    = prsel_pkg::BTN_NONE;
               priority if (!anchor_vld_ff) begin
                  // first click: drop the anchor here
                  anchor_x_in     = s1_cx_ff;
                  anchor_y_in     = s1_cy_ff;
                  anchor_vld_in   = 1'b1;
                  anchor_btn_in   = held_ff;
                  prev_rect_in    = point_rect;
                  prev_vld_in     = 1'b1;
                  res.flow        = prsel_pkg::FLOW_CLICK;
                  res.has_preview = 1'b1;
                  res.preview     = point_rect;
               end else if (held_ff == anchor_btn_ff) begin
                  // second click: commit anchor to cursor
                  res.flow        = prsel_pkg::FLOW_CLICK;
                  res.has_preview = prev_vld_ff;
                  res.preview     = last_rect;
                  res.committed   = 1'b1;
                  res.commit      = hover_rect;
                  anchor_vld_in   = 1'b0;
                  anchor_btn_in   = prsel_pkg::BTN_NONE;
                  prev_vld_in     = 1'b0;
               end else begin
                  // other button: cancel the anchor
                  res.flow      = prsel_pkg::FLOW_MISC;
                  anchor_vld_in = 1'b0;
                  anchor_btn_in = prsel_pkg::BTN_NONE;
                  prev_vld_in   = 1'b0;
               end
            end else begin
               pressed_in = 1'b0;
               drag_in    = 1'b0;
               held_in    = prsel_pkg::BTN_NONE;
               res.flow   = prsel_pkg::FLOW_MISC;
            end
         end
         default: begin
            // undefined mode: ignore
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pressed_ff    <= 1'b0;
         drag_ff       <= 1'b0;
         held_ff       <= prsel_pkg::BTN_NONE;
         anchor_vld_ff <= 1'b0;
         anchor_btn_ff <= prsel_pkg::BTN_NONE;
         prev_vld_ff   <= 1'b0;
      end else if (s1_adv) begin
         pressed_ff    <= pressed_in;
         drag_ff       <= drag_in;
         held_ff       <= held_in;
         anchor_vld_ff <= anchor_vld_in;
         anchor_btn_ff <= anchor_btn_in;
         prev_vld_ff   <= prev_vld_in;
      end
   end

   // points and rectangle are only read while their flags are set
   always_ff @(posedge clock) begin
      if (s1_adv) begin
         press_x_ff   <= press_x_in;
         press_y_ff   <= press_y_in;
         anchor_x_ff  <= anchor_x_in;
         anchor_y_ff  <= anchor_y_in;
         prev_rect_ff <= prev_rect_in;
      end
   end

   // ---------------------------------------------------------------------
   // Result register
   // ---------------------------------------------------------------------
   always_comb begin
      rsp_item_in = res;
      // unused rectangles read as zero
      if (!res.has_preview) begin
         rsp_item_in.preview = '0;
      end
      if (!res.committed) begin
         rsp_item_in.commit = '0;
      end
      if (s1_adv) begin
         rsp_valid_in = emit;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv && emit) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.result_kind    = rsp_item_ff.result_kind;
   assign rsp_ch.flow           = rsp_item_ff.flow;
   assign rsp_ch.has_preview    = rsp_item_ff.has_preview;
   assign rsp_ch.preview_left   = rsp_item_ff.preview.left;
   assign rsp_ch.preview_top    = rsp_item_ff.preview.top;
   assign rsp_ch.preview_right  = rsp_item_ff.preview.right;
   assign rsp_ch.preview_bottom = rsp_item_ff.preview.bottom;
   assign rsp_ch.committed      = rsp_item_ff.committed;
   assign rsp_ch.commit_left    = rsp_item_ff.commit.left;
   assign rsp_ch.commit_top     = rsp_item_ff.commit.top;
   assign rsp_ch.commit_right   = rsp_item_ff.commit.right;
   assign rsp_ch.commit_bottom  = rsp_item_ff.commit.bottom;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   `AST_SAME(a_anchor_btn, anchor_vld_ff,
             anchor_btn_ff == prsel_pkg::BTN_LEFT || anchor_btn_ff == prsel_pkg::BTN_RIGHT,
             "anchor held by a button that cannot click")
   `AST_NEXT(a_press_sets, s1_adv && s1_mode_ff == prsel_pkg::MODE_PRESS,
             pressed_ff && !drag_ff, "press did not latch pressed state")
   `AST_SAME(a_move_no_commit,
             rsp_valid_ff && rsp_item_ff.result_kind == prsel_pkg::KIND_UPDATE,
             !rsp_item_ff.committed && rsp_item_ff.has_preview,
             "move result with commit or without preview")
   `AST_SAME(a_drag_commits,
             rsp_valid_ff && rsp_item_ff.result_kind == prsel_pkg::KIND_RELEASE
                && rsp_item_ff.flow == prsel_pkg::FLOW_SWEEP,
             rsp_item_ff.committed, "drag release without commit")

endmodule

`default_nettype wire
